[rtl/sfcp_pkg.sv]
// ----------------------------------------------------------------------------
// sfcp_pkg
// Types and constants for the sensor frame checksum parser.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcp_pkg;

    localparam int SAMPLE_DEPTH = 1024;
    localparam int COUNT_W      = $clog2(SAMPLE_DEPTH + 1);
    localparam int INDEX_W      = 10;

    localparam logic [7:0]         HDR_BYTE   = 8'h5A;
    localparam logic [2:0]         FIRST_POS  = 3'd0;
    localparam logic [2:0]         SECOND_POS = 3'd1;
    localparam logic [2:0]         HIGH_POS   = 3'd4;
    localparam logic [2:0]         LOW_POS    = 3'd5;
    localparam logic [2:0]         CHECK_POS  = 3'd7;
    localparam logic [COUNT_W-1:0] COUNT_MAX  = COUNT_W'(SAMPLE_DEPTH);
    localparam logic [INDEX_W-1:0] SAT_INDEX  = INDEX_W'(SAMPLE_DEPTH - 1);

    typedef enum logic [1:0] {
        OP_BYTE  = 2'd0,
        OP_START = 2'd1,
        OP_STOP  = 2'd2,
        OP_RESET = 2'd3
    } opcode_t;

    typedef struct packed {
        opcode_t    opcode;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic [15:0]        distance;
        logic [INDEX_W-1:0] sample_index;
        logic               overflow;
    } out_item_t;

endpackage

`default_nettype wire

[rtl/sfcp_parser.sv]
// ----------------------------------------------------------------------------
// sfcp_parser
// Frame state, running checksum and sample counter; one request per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcp_parser import sfcp_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_accept,
    input  wire in_item_t  in_item,
    output logic           res_valid,
    output out_item_t      res_item
);

    logic               enable_reg,  enable_next;
    logic [2:0]         pos_reg,     pos_next;
    logic [7:0]         sum_reg,     sum_next;
    logic [7:0]         high_reg,    high_next;
    logic [7:0]         low_reg,     low_next;
    logic [COUNT_W-1:0] count_reg,   count_next;

    logic [7:0] b;
    logic       full;

    assign b    = in_item.rx_byte;
    assign full = (count_reg >= COUNT_MAX);

    always_comb begin
        enable_next = enable_reg;
        pos_next    = pos_reg;
        sum_next    = sum_reg;
        high_next   = high_reg;
        low_next    = low_reg;
        count_next  = count_reg;
        res_valid   = 1'b0;
        res_item.distance     = {high_reg, low_reg};
        res_item.sample_index = full ? SAT_INDEX : INDEX_W'(count_reg);
        res_item.overflow     = full;
        if (in_accept) begin
            unique case (in_item.opcode)
                OP_START: begin
                    enable_next = 1'b1;
                    count_next  = '0;
                end
                OP_STOP: begin
                    enable_next = 1'b0;
                end
                OP_RESET: begin
                    enable_next = 1'b0;
                    count_next  = '0;
                end
                OP_BYTE: begin
                    if (enable_reg) begin
                        priority if (pos_reg == FIRST_POS) begin
                            if (b == HDR_BYTE) begin
                                sum_next = b;
                                pos_next = SECOND_POS;
                            end
                        end else if (pos_reg == SECOND_POS && b != HDR_BYTE) begin
                            pos_next = FIRST_POS;
                        end else if (pos_reg != CHECK_POS) begin
                            if (pos_reg == HIGH_POS) high_next = b;
                            if (pos_reg == LOW_POS)  low_next  = b;
                            sum_next = sum_reg + b;
                            pos_next = pos_reg + 3'd1;
                        end else begin
                            pos_next = FIRST_POS;
                            if (b == sum_reg) begin
                                res_valid = 1'b1;
                                if (!full) count_next = count_reg + COUNT_W'(1);
                            end
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= 1'b0;
            pos_reg    <= '0;
            sum_reg    <= '0;
            high_reg   <= '0;
            low_reg    <= '0;
            count_reg  <= '0;
        end else begin
            enable_reg <= enable_next;
            pos_reg    <= pos_next;
            sum_reg    <= sum_next;
            high_reg   <= high_next;
            low_reg    <= low_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/sfcp_out_buf.sv]
// ----------------------------------------------------------------------------
// sfcp_out_buf
// Result register with a skid entry; ready toward the input is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcp_out_buf import sfcp_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      in_valid,
    input  wire out_item_t in_item,
    output logic           in_ready,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic      main_valid_reg, main_valid_next;
    logic      skid_valid_reg, skid_valid_next;
    out_item_t main_reg,       main_next;
    out_item_t skid_reg,       skid_next;
    logic      push;

    assign in_ready = !skid_valid_reg;
    assign push     = in_valid && in_ready;
    assign m_valid  = main_valid_reg;
    assign m_data   = main_reg;

    always_comb begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (m_ready || !main_valid_reg) begin
            if (skid_valid_reg) begin
                main_valid_next = 1'b1;
                main_next       = skid_reg;
                skid_valid_next = 1'b0;
            end else begin
                main_valid_next = push;
                main_next       = in_item;
            end
        end else if (push) begin
            skid_valid_next = 1'b1;
            skid_next       = in_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

endmodule

`default_nettype wire

[rtl/sensor_frame_checksum_parser.sv]
// ----------------------------------------------------------------------------
// sensor_frame_checksum_parser
// Parses 8-byte sensor frames with double header and sum checksum.
// ----------------------------------------------------------------------------
// Throughput: one request per cycle while s_ready is high; the running
// checksum settles each byte in the cycle it is accepted, and a skid entry
// absorbs one stalled result. A result is registered before m_valid shows it.
// Reset: synchronous active-low aresetn disables reception and clears frame
// position, checksum, distance bytes, sample count and the result buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module sensor_frame_checksum_parser import sfcp_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire in_item_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output out_item_t      m_data
);

    logic      accept;
    logic      res_valid;
    out_item_t res_item;

    assign accept = s_valid && s_ready;

    sfcp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (accept),
        .in_item   (s_data),
        .res_valid (res_valid),
        .res_item  (res_item)
    );

    sfcp_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (res_valid),
        .in_item  (res_item),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

`default_nettype wire
